// ===== hw/rtl/fcc_pkg.sv =====
// Shared types and constants for the frame checker/classifier.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package fcc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 10;   // frame_length and block size width
  localparam int unsigned StatusW  = 3;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned MaxCountDefault = 1023;
  localparam int unsigned ModelIdx = 199;  // byte holding the model revision
  localparam int unsigned MinFrame = 3;
  localparam int unsigned ModelMin = 3;

  // status codes
  localparam logic [StatusW-1:0] ST_VALID     = 3'd0;
  localparam logic [StatusW-1:0] ST_SHORT     = 3'd1;
  localparam logic [StatusW-1:0] ST_LEN_ERR   = 3'd2;
  localparam logic [StatusW-1:0] ST_HDR_ERR   = 3'd3;
  localparam logic [StatusW-1:0] ST_CSUM_ERR  = 3'd4;

  // block kinds
  localparam logic [KindW-1:0] KIND_MAIN    = 2'd0;
  localparam logic [KindW-1:0] KIND_EXTRA   = 2'd1;
  localparam logic [KindW-1:0] KIND_OPT     = 2'd2;
  localparam logic [KindW-1:0] KIND_UNKNOWN = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_HDR_READ   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HDR_INIT   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAIN_SIZE  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MAIN_TYPE  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_EXTRA_SIZE = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_EXTRA_TYPE = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_OPT_SIZE   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_OPT_TYPE   = 3'd7;

  typedef struct packed {
    logic [ByteW-1:0] hdr_read;
    logic [ByteW-1:0] hdr_init;
    logic [LenW-1:0]  main_size;
    logic [ByteW-1:0] main_type;
    logic [LenW-1:0]  extra_size;
    logic [ByteW-1:0] extra_type;
    logic [LenW-1:0]  opt_size;
    logic [ByteW-1:0] opt_type;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    hdr_read:   8'd113,
    hdr_init:   8'd49,
    main_size:  10'd203,
    main_type:  8'd16,
    extra_size: 10'd203,
    extra_type: 8'd33,
    opt_size:   10'd20,
    opt_type:   8'd80
  };

  // one accepted input beat held in the input register
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [ByteW-1:0] data;
  } beat_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [KindW-1:0]   kind;
    logic               extra;
    logic [LenW-1:0]    length;
  } verdict_t;

endpackage

`default_nettype wire

// ===== hw/rtl/frame_checker_classifier.sv =====
// Frame checker/classifier top level: input register, frame evaluation,
// result register. Depends on fcc_pkg, fcc_cfg_regs, fcc_in_stage, fcc_frame_eval.
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+---------------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata[7:0] frame_byte, tlast is_last
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tuser status, block_kind;
//            |     |                               | tdata extra_available, frame_length
//  cfg       | in  | cfg_we_i (no back-pressure)   | cfg_addr_i index, cfg_wdata_i value
//
// One byte per cycle sustained unless a last byte stalls. A beat is held in the
// input register, where it updates the frame state; on the last byte the verdict
// is loaded into the result register, which drives m_axis_tvalid. A last byte
// waits in the input register while an unread verdict is held, and the input
// stalls behind it until m_axis_tready is seen.
// Reset clears frame state, sticky flag and configuration registers to their defaults.
`default_nettype none

module frame_checker_classifier #(
  parameter int unsigned MaxCount = fcc_pkg::MaxCountDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,   // [7:0] frame_byte
  input  wire logic                         s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [15:0]                       m_axis_tdata,   // [0] extra_available,
                                                            // [10:1] frame_length
  output logic [4:0]                        m_axis_tuser,   // [2:0] status,
                                                            // [4:3] block_kind
  output logic                              m_axis_tlast,
  input  wire logic                         cfg_we_i,
  input  wire logic [fcc_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  wire logic [fcc_pkg::CfgDataW-1:0] cfg_wdata_i
);

  fcc_pkg::cfg_t     cfg;
  fcc_pkg::beat_t    beat;
  fcc_pkg::verdict_t verdict;
  fcc_pkg::verdict_t res_q;
  logic              res_valid_d, res_valid_q;
  logic              res_free, advance;

  fcc_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  assign res_free = !res_valid_q || m_axis_tready;
  assign advance  = beat.valid && (!beat.last || res_free);

  fcc_in_stage u_in (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .advance_i  (advance),
    .beat_o     (beat)
  );

  fcc_frame_eval #(
    .MaxCount (MaxCount)
  ) u_eval (
    .clk_i,
    .rst_ni,
    .cfg_i     (cfg),
    .beat_i    (beat),
    .fire_i    (advance),
    .verdict_o (verdict)
  );

  always_comb begin
    res_valid_d = res_valid_q;
    if (advance && beat.last) begin
      res_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && beat.last) begin
      res_q <= verdict;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tlast  = 1'b1;  // each verdict is a one-beat packet
  assign m_axis_tuser  = {res_q.kind, res_q.status};
  assign m_axis_tdata  = {5'd0, res_q.length, res_q.extra};

endmodule

`default_nettype wire

// ===== hw/rtl/fcc_cfg_regs.sv =====
// Configuration register file of the frame checker.
// Depends on fcc_pkg.
`default_nettype none

module fcc_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [fcc_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  wire logic [fcc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output fcc_pkg::cfg_t                     cfg_o
);

  fcc_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        fcc_pkg::REG_HDR_READ:   cfg_d.hdr_read   = cfg_wdata_i[fcc_pkg::ByteW-1:0];
        fcc_pkg::REG_HDR_INIT:   cfg_d.hdr_init   = cfg_wdata_i[fcc_pkg::ByteW-1:0];
        fcc_pkg::REG_MAIN_SIZE:  cfg_d.main_size  = cfg_wdata_i[fcc_pkg::LenW-1:0];
        fcc_pkg::REG_MAIN_TYPE:  cfg_d.main_type  = cfg_wdata_i[fcc_pkg::ByteW-1:0];
        fcc_pkg::REG_EXTRA_SIZE: cfg_d.extra_size = cfg_wdata_i[fcc_pkg::LenW-1:0];
        fcc_pkg::REG_EXTRA_TYPE: cfg_d.extra_type = cfg_wdata_i[fcc_pkg::ByteW-1:0];
        fcc_pkg::REG_OPT_SIZE:   cfg_d.opt_size   = cfg_wdata_i[fcc_pkg::LenW-1:0];
        fcc_pkg::REG_OPT_TYPE:   cfg_d.opt_type   = cfg_wdata_i[fcc_pkg::ByteW-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= fcc_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fcc_in_stage.sv =====
// Input register of the frame checker: holds one accepted beat.
// Depends on fcc_pkg.
`default_nettype none

module fcc_in_stage (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic [fcc_pkg::ByteW-1:0] in_data_i,
  input  wire logic                      in_last_i,
  output logic                           in_ready_o,
  input  wire logic                      advance_i,  // held beat is consumed this cycle
  output fcc_pkg::beat_t                 beat_o
);

  logic                      valid_d, valid_q;
  logic                      last_q;
  logic [fcc_pkg::ByteW-1:0] data_q;
  logic                      take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= in_data_i;
      last_q <= in_last_i;
    end
  end

  assign beat_o = '{valid: valid_q, last: last_q, data: data_q};

endmodule

`default_nettype wire

// ===== hw/rtl/fcc_frame_eval.sv =====
// Per-frame state (count, sum, captured bytes), sticky flag and verdict logic.
// Depends on fcc_pkg.
`default_nettype none

module fcc_frame_eval #(
  parameter int unsigned MaxCount = fcc_pkg::MaxCountDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire fcc_pkg::cfg_t  cfg_i,
  input  wire fcc_pkg::beat_t beat_i,
  input  wire logic           fire_i,     // beat_i is consumed this cycle
  output fcc_pkg::verdict_t   verdict_o   // meaningful when a last beat fires
);

  localparam int unsigned CntBits = $clog2(MaxCount + 1);
  localparam int unsigned CntW    = (CntBits > fcc_pkg::LenW) ? CntBits : fcc_pkg::LenW;

  logic [CntW-1:0]           cnt_d, cnt_q;
  logic [fcc_pkg::ByteW-1:0] sum_d, sum_q;
  logic [fcc_pkg::ByteW-1:0] first_d, first_q;
  logic [fcc_pkg::ByteW-1:0] len_d, len_q;
  logic [fcc_pkg::ByteW-1:0] type_d, type_q;
  logic                      model_d, model_q;
  logic                      extra_d, extra_q;

  logic [CntW-1:0]           cnt_n;
  logic [fcc_pkg::ByteW-1:0] sum_n, first_n, len_n, type_n;
  logic                      model_n;
  logic                      hdr_read_hit, hdr_ok;
  logic                      set_extra;

  // state as it stands after the current beat
  always_comb begin
    first_n = (cnt_q == CntW'(0)) ? beat_i.data : first_q;
    len_n   = (cnt_q == CntW'(1)) ? beat_i.data : len_q;
    type_n  = (cnt_q == CntW'(3)) ? beat_i.data : type_q;
    model_n = (cnt_q == CntW'(fcc_pkg::ModelIdx))
              ? (beat_i.data >= fcc_pkg::ByteW'(fcc_pkg::ModelMin)) : model_q;
    sum_n   = sum_q + beat_i.data;
    cnt_n   = (cnt_q < CntW'(MaxCount)) ? cnt_q + CntW'(1) : cnt_q;
  end

  always_comb begin
    hdr_read_hit = (first_n == cfg_i.hdr_read);
    hdr_ok       = hdr_read_hit || (first_n == cfg_i.hdr_init);

    if (cnt_n < CntW'(fcc_pkg::MinFrame)) begin
      verdict_o.status = fcc_pkg::ST_SHORT;
    end else if (CntW'(len_n) + CntW'(fcc_pkg::MinFrame) != cnt_n) begin
      verdict_o.status = fcc_pkg::ST_LEN_ERR;
    end else if (!hdr_ok) begin
      verdict_o.status = fcc_pkg::ST_HDR_ERR;
    end else if (sum_n != '0) begin
      verdict_o.status = fcc_pkg::ST_CSUM_ERR;
    end else begin
      verdict_o.status = fcc_pkg::ST_VALID;
    end

    set_extra      = 1'b0;
    verdict_o.kind = fcc_pkg::KIND_UNKNOWN;
    if (verdict_o.status == fcc_pkg::ST_VALID) begin
      if (cnt_n == CntW'(cfg_i.main_size) && type_n == cfg_i.main_type) begin
        verdict_o.kind = fcc_pkg::KIND_MAIN;
        set_extra      = hdr_read_hit && model_n;
      end else if (cnt_n == CntW'(cfg_i.extra_size) && type_n == cfg_i.extra_type) begin
        verdict_o.kind = fcc_pkg::KIND_EXTRA;
      end else if (cnt_n == CntW'(cfg_i.opt_size) && type_n == cfg_i.opt_type) begin
        verdict_o.kind = fcc_pkg::KIND_OPT;
      end
    end

    verdict_o.extra  = extra_q || set_extra;
    verdict_o.length = cnt_n[fcc_pkg::LenW-1:0];
  end

  always_comb begin
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    first_d = first_q;
    len_d   = len_q;
    type_d  = type_q;
    model_d = model_q;
    extra_d = extra_q;
    if (fire_i) begin
      if (beat_i.last) begin
        // verdict given: start a fresh frame
        cnt_d   = '0;
        sum_d   = '0;
        first_d = '0;
        len_d   = '0;
        type_d  = '0;
        model_d = 1'b0;
        extra_d = verdict_o.extra;
      end else begin
        cnt_d   = cnt_n;
        sum_d   = sum_n;
        first_d = first_n;
        len_d   = len_n;
        type_d  = type_n;
        model_d = model_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sum_q   <= '0;
      first_q <= '0;
      len_q   <= '0;
      type_q  <= '0;
      model_q <= 1'b0;
      extra_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      first_q <= first_d;
      len_q   <= len_d;
      type_q  <= type_d;
      model_q <= model_d;
      extra_q <= extra_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fcc_checker.sv =====
// Port-level checks for frame_checker_classifier, attached by bind.
// Depends on fcc_pkg.
`default_nettype none

module fcc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [4:0]  m_axis_tuser
);

  // a held verdict must not change under back-pressure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("verdict changed while stalled");

  // every frame holds at least one byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[10:1] != 10'd0)
    else $error("verdict with zero frame length");

  // a rejected frame is never classified
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2:0] != fcc_pkg::ST_VALID |->
      m_axis_tuser[4:3] == fcc_pkg::KIND_UNKNOWN)
    else $error("invalid frame given a block kind");

  // a valid frame is at least the minimum length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2:0] == fcc_pkg::ST_VALID |->
      m_axis_tdata[10:1] >= 10'(fcc_pkg::MinFrame))
    else $error("valid verdict on a short frame");

  // a fresh verdict follows the handshake of a last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("verdict appeared without a frame");

endmodule

bind frame_checker_classifier fcc_checker u_fcc_checker (.*);

`default_nettype wire
